### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define FHFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define FHFA_NEVER(lbl, expr, msg) \
    `FHFA_ASSERT(lbl, !(expr), msg)

`endif

### sv/fhfa_pkg.sv
// ----------------------------------------------------------------------------
// fhfa_pkg
// Shared widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package fhfa_pkg;

    localparam int MAX_HOLES  = 16;
    localparam int ADDR_BITS  = 16;

    localparam int IDX_W      = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W      = $clog2(MAX_HOLES + 1);

    localparam int KIND_W     = 1;
    localparam int BASE_W     = 16;
    localparam int SIZE_W     = 17;
    localparam int PID_W      = 16;
    localparam int SEG_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int POLICY_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int ENTRY_W    = SIZE_W + BASE_W;

    // Base addresses wrap at 2^ADDR_BITS, then are kept in BASE_W bits.
    localparam logic [BASE_W-1:0] ADDR_MASK = BASE_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [SIZE_W-1:0]   MEM_SIZE_RESET = SIZE_W'(65536);

    localparam logic [KIND_W-1:0]   KIND_ALLOC  = 1'b0;
    localparam logic [KIND_W-1:0]   KIND_APPEND = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPACT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE = 1'b1;

    typedef struct packed {
        logic capture;        // latch the accepted beat, reset the scan
        logic append_commit;  // store an appended hole and load its result
        logic scan_step;      // advance the fit scan by one entry
        logic shift_start;    // point the read side one past the picked hole
        logic shift_step;     // move one entry down over the removed hole
        logic finish;         // update the table and load the allocate result
    } fhfa_cmd_t;

    typedef struct packed {
        logic             walk_done;  // read side exhausted and pipe drained
        logic             found;
        logic             exact;
        logic             out_free;
        logic [CNT_W-1:0] hole_count;
    } fhfa_sts_t;

endpackage

### sv/fhfa_if.sv
// ----------------------------------------------------------------------------
// fhfa channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface fhfa_item_if;
    import fhfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [PID_W-1:0]    process_id;
    logic [SEG_W-1:0]    segment_number;
    logic [SIZE_W-1:0]   request_size;
    logic [BASE_W-1:0]   new_hole_base;
    logic [SIZE_W-1:0]   new_hole_size;

    modport source (
        output valid, kind, process_id, segment_number, request_size,
               new_hole_base, new_hole_size,
        input  ready
    );
    modport sink (
        input  valid, kind, process_id, segment_number, request_size,
               new_hole_base, new_hole_size,
        output ready
    );
endinterface

interface fhfa_result_if;
    import fhfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BASE_W-1:0]   segment_base;
    logic [SIZE_W-1:0]   segment_size;
    logic [PID_W-1:0]    owner_process;
    logic [SEG_W-1:0]    owner_segment;

    modport source (
        output valid, status, segment_base, segment_size, owner_process, owner_segment,
        input  ready
    );
    modport sink (
        input  valid, status, segment_base, segment_size, owner_process, owner_segment,
        output ready
    );
endinterface

### sv/fhfa_ram.sv
// ----------------------------------------------------------------------------
// fhfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/fhfa_datapath.sv
// ----------------------------------------------------------------------------
// fhfa_datapath
// Hole table, config registers, fit scan compare, shift walk, result register.
// ----------------------------------------------------------------------------
module fhfa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fhfa_pkg::fhfa_cmd_t            cmd,
    output fhfa_pkg::fhfa_sts_t            sts,
    input  logic                           cfg_we,
    input  logic [fhfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fhfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [fhfa_pkg::PID_W-1:0]     in_process_id,
    input  logic [fhfa_pkg::SEG_W-1:0]     in_segment_number,
    input  logic [fhfa_pkg::SIZE_W-1:0]    in_request_size,
    input  logic [fhfa_pkg::BASE_W-1:0]    in_new_hole_base,
    input  logic [fhfa_pkg::SIZE_W-1:0]    in_new_hole_size,
    fhfa_result_if.source                  result
);
    import fhfa_pkg::*;

    // config
    logic [POLICY_W-1:0] policy_reg;
    logic [SIZE_W-1:0]   memsize_reg;

    // table bookkeeping and walk control
    logic [CNT_W-1:0]    hole_count_reg, hole_count_next;
    logic [CNT_W-1:0]    walk_idx_reg, walk_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                found_reg, found_next;

    // captured beat and pick
    logic [SIZE_W-1:0]   req_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [BASE_W-1:0]   nbase_reg;
    logic [SIZE_W-1:0]   nsize_reg;
    logic [IDX_W-1:0]    pick_idx_reg, pick_idx_next;
    logic [BASE_W-1:0]   pick_base_reg, pick_base_next;
    logic [SIZE_W-1:0]   pick_size_reg, pick_size_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BASE_W-1:0]   out_base_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic [PID_W-1:0]    out_pid_reg;
    logic [SEG_W-1:0]    out_seg_reg;
    logic                load_result;

    // RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [SIZE_W-1:0]   rd_size;
    logic [BASE_W-1:0]   rd_base;

    logic                walk_more;
    logic                table_full;
    logic                fits;
    logic                take;
    logic                walking;

    fhfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_HOLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (walk_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_size    = ram_rdata[ENTRY_W-1:BASE_W];
    assign rd_base    = ram_rdata[BASE_W-1:0];
    assign walk_more  = (walk_idx_reg < hole_count_reg);
    assign table_full = (hole_count_reg >= CNT_W'(MAX_HOLES));
    assign walking    = cmd.scan_step || cmd.shift_step;
    assign ram_re     = walking && walk_more;
    assign fits       = (rd_size >= req_reg);
    assign load_result = cmd.append_commit || cmd.finish;

    // fit decision for the entry coming out of the RAM
    always_comb
    begin
        case (policy_reg)
            POL_BEST:
                take = fits && (rd_size <= memsize_reg) &&
                       (!found_reg || (rd_size < pick_size_reg));
            POL_WORST:
                take = fits && (!found_reg || (rd_size >= pick_size_reg));
            default:
                take = fits && !found_reg;
        endcase
    end

    // walk pointer, pick tracking, hole count
    always_comb
    begin
        walk_idx_next   = walk_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_base_next  = pick_base_reg;
        pick_size_next  = pick_size_reg;
        hole_count_next = hole_count_reg;

        if (cmd.capture)
        begin
            walk_idx_next  = '0;
            chk_valid_next = 1'b0;
            found_next     = 1'b0;
        end
        else if (cmd.shift_start)
        begin
            walk_idx_next  = CNT_W'(pick_idx_reg) + CNT_W'(1);
            chk_valid_next = 1'b0;
        end
        else if (walking)
        begin
            chk_valid_next = walk_more;
            if (walk_more)
            begin
                walk_idx_next = walk_idx_reg + CNT_W'(1);
                chk_idx_next  = walk_idx_reg[IDX_W-1:0];
            end
        end

        if (cmd.scan_step && chk_valid_reg && take)
        begin
            found_next     = 1'b1;
            pick_idx_next  = chk_idx_reg;
            pick_base_next = rd_base;
            pick_size_next = rd_size;
        end

        if (cmd.append_commit && !table_full)
        begin
            hole_count_next = hole_count_reg + CNT_W'(1);
        end
        else if (cmd.finish && found_reg && (pick_size_reg == req_reg))
        begin
            hole_count_next = hole_count_reg - CNT_W'(1);
        end
    end

    // table write port: append, shift, shrink
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pick_idx_reg;
        ram_wdata = {pick_size_reg - req_reg,
                     (pick_base_reg + req_reg[BASE_W-1:0]) & ADDR_MASK};
        if (cmd.append_commit)
        begin
            ram_we    = !table_full;
            ram_waddr = hole_count_reg[IDX_W-1:0];
            ram_wdata = {nsize_reg, nbase_reg};
        end
        else if (cmd.shift_step)
        begin
            ram_we    = chk_valid_reg;
            ram_waddr = chk_idx_reg - IDX_W'(1);
            ram_wdata = ram_rdata;
        end
        else if (cmd.finish)
        begin
            ram_we = found_reg && (pick_size_reg != req_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= POL_FIRST;
            memsize_reg    <= MEM_SIZE_RESET;
            hole_count_reg <= '0;
            walk_idx_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FIT_POLICY:  policy_reg  <= cfg_wdata[POLICY_W-1:0];
                    REG_MEMORY_SIZE: memsize_reg <= cfg_wdata[SIZE_W-1:0];
                    default:         ;
                endcase
            end
            hole_count_reg <= hole_count_next;
            walk_idx_reg   <= walk_idx_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        pick_idx_reg  <= pick_idx_next;
        pick_base_reg <= pick_base_next;
        pick_size_reg <= pick_size_next;
        if (cmd.capture)
        begin
            req_reg   <= in_request_size;
            pid_reg   <= in_process_id;
            seg_reg   <= in_segment_number;
            nbase_reg <= in_new_hole_base;
            nsize_reg <= in_new_hole_size;
        end
        if (cmd.append_commit)
        begin
            out_status_reg <= table_full ? ST_FULL : ST_OK;
            out_base_reg   <= '0;
            out_size_reg   <= '0;
            out_pid_reg    <= '0;
            out_seg_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            out_status_reg <= found_reg ? ST_OK : ST_COMPACT;
            out_base_reg   <= found_reg ? pick_base_reg : '0;
            out_size_reg   <= found_reg ? req_reg : '0;
            out_pid_reg    <= found_reg ? pid_reg : '0;
            out_seg_reg    <= found_reg ? seg_reg : '0;
        end
    end

    assign sts.walk_done  = !walk_more && !chk_valid_reg;
    assign sts.found      = found_reg;
    assign sts.exact      = (pick_size_reg == req_reg);
    assign sts.out_free   = !out_valid_reg || result.ready;
    assign sts.hole_count = hole_count_reg;

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.segment_base  = out_base_reg;
    assign result.segment_size  = out_size_reg;
    assign result.owner_process = out_pid_reg;
    assign result.owner_segment = out_seg_reg;
endmodule

### sv/fhfa_ctrl.sv
// ----------------------------------------------------------------------------
// fhfa_ctrl
// Sequencer: accept, append or scan, optional shift, commit result.
// ----------------------------------------------------------------------------
module fhfa_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [fhfa_pkg::KIND_W-1:0] item_kind,
    output logic                        item_ready,
    output fhfa_pkg::fhfa_cmd_t         cmd,
    input  fhfa_pkg::fhfa_sts_t         sts
);
    import fhfa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPEND = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (item_kind == KIND_APPEND) ? S_APPEND : S_SCAN;
                end
            end
            S_APPEND:
            begin
                if (sts.out_free)
                begin
                    cmd.append_commit = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!sts.walk_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (sts.found && sts.exact)
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (!sts.walk_done)
                begin
                    cmd.shift_step = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### sv/free_hole_fit_allocator.sv
// ----------------------------------------------------------------------------
// free_hole_fit_allocator
// First/best/worst fit allocation over an ordered table of free holes.
// ----------------------------------------------------------------------------
// Sequence, from accepting a beat to loading its result: an append commits
//   directly; an allocate scans every hole in the table, and when hole P is
//   used exactly the later entries shift down over it before the finish
//   commit updates the table and loads the result.
// Throughput: one beat in flight; the next beat is taken the cycle after the
//   result is loaded, and a result held by the sink holds the commit.
// Reset: table empty, fit_policy first fit, memory_size 65536; no clear pass.
`include "assert_macros.svh"

module free_hole_fit_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    fhfa_item_if.sink                      item,
    fhfa_result_if.source                  result,
    input  logic                           cfg_we,
    input  logic [fhfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fhfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import fhfa_pkg::*;

    fhfa_cmd_t cmd;
    fhfa_sts_t sts;
    logic      commit;

    // Controller: takes one beat at a time and sequences the datapath through
    // append, fit scan, optional shift-down walk and the final table update.
    fhfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_ready (item.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Datapath: hole table RAM, config registers, pipelined scan compare
    // (read index i while comparing entry i-1), and the result register that
    // holds a finished beat while the sink stalls.
    fhfa_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .in_process_id     (item.process_id),
        .in_segment_number (item.segment_number),
        .in_request_size   (item.request_size),
        .in_new_hole_base  (item.new_hole_base),
        .in_new_hole_size  (item.new_hole_size),
        .result            (result)
    );

    assign commit = cmd.append_commit || cmd.finish;

    // Leave idle right after taking a beat.
    `FHFA_ASSERT(a_busy_after_accept, item.valid && item.ready |=> !item.ready, "ready held")
    // A result beat appears only from an append or finish commit.
    `FHFA_ASSERT(a_result_from_commit, $rose(result.valid) |-> $past(commit), "stray result")
    // Hole count stays within the table.
    `FHFA_NEVER(a_count_in_range, sts.hole_count > CNT_W'(MAX_HOLES), "hole count overflow")
    // Hole count moves only on a commit.
    `FHFA_ASSERT(a_count_steady, !commit |=> $stable(sts.hole_count), "count moved")

endmodule
